[hdl/lfps_pkg.sv]
// ----------------------------------------------------------------------------
// lfps_pkg: shared types and constants for the line-follow PID steering block
// Configuration record, register indexes, operation codes, sequencer states
// and unit status.
// ----------------------------------------------------------------------------
package lfps_pkg;

   // datapath widths
   localparam int WORD_W = 64;   // accumulator and remainder width
   localparam int MULB_W = 20;   // serial multiplier operand width
   localparam int QUOT_W = 16;   // quotient bits produced by the divider
   localparam int DIVS_W = 35;   // divisor width
   localparam int LIM_W  = 31;   // integral bound, limit times 1000
   localparam int INTG_W = 32;   // clamped integral
   localparam int CNT_W  = 5;    // divider step counter

   // register reset values
   localparam logic [15:0] GAIN_P_RST    = 16'd512;
   localparam logic [15:0] GAIN_I_RST    = 16'd26;
   localparam logic [15:0] GAIN_D_RST    = 16'd102;
   localparam logic [14:0] MAX_STEER_RST = 15'd1750;
   localparam logic [19:0] INT_LIMIT_RST = 20'd100;

   // operation codes carried in tuser
   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_RESET = 1'b1;

   // scale constants fed to the serial multiplier
   localparam logic [MULB_W-1:0] K_MILLI = 20'd1000;
   localparam logic [MULB_W-1:0] K_MICRO = 20'd1000000;

   typedef struct packed {
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [14:0] max_steer;
      logic [19:0] integral_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      REG_GAIN_P,
      REG_GAIN_I,
      REG_GAIN_D,
      REG_MAX_STEER,
      REG_INT_LIMIT
   } reg_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,   // wait for a transaction
      ST_LIM,    // limit times 1000
      ST_INT,    // integral plus e*t, then clamp
      ST_PE,     // gain_p * e
      ST_PK,     // times 1000
      ST_IG,     // plus gain_i * integral
      ST_TM,     // times t
      ST_DE,     // gain_d * position change
      ST_DM,     // times 1e6, plus held sum
      ST_DT,     // t times 1000
      ST_DV1,    // numerator / (256000 t)
      ST_SP,     // |base| * speed scale
      ST_DV2,    // divide by 10 m
      ST_OUT     // hand result to output register
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

[hdl/lfps_csr.sv]
// ----------------------------------------------------------------------------
// lfps_csr: configuration registers
// APB-style register file holding the gains, steering clamp and integral bound.
// ----------------------------------------------------------------------------
module lfps_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output lfps_pkg::cfg_type    cfg
);
   import lfps_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx        = reg_idx_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // decode write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_GAIN_P:    cfg_in.gain_p         = csr_pwdata[15:0];
            REG_GAIN_I:    cfg_in.gain_i         = csr_pwdata[15:0];
            REG_GAIN_D:    cfg_in.gain_d         = csr_pwdata[15:0];
            REG_MAX_STEER: cfg_in.max_steer      = csr_pwdata[14:0];
            REG_INT_LIMIT: cfg_in.integral_limit = csr_pwdata[19:0];
            default:       cfg_in                = cfg_ff;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         REG_GAIN_P:    csr_prdata = {16'd0, cfg_ff.gain_p};
         REG_GAIN_I:    csr_prdata = {16'd0, cfg_ff.gain_i};
         REG_GAIN_D:    csr_prdata = {16'd0, cfg_ff.gain_d};
         REG_MAX_STEER: csr_prdata = {17'd0, cfg_ff.max_steer};
         REG_INT_LIMIT: csr_prdata = {12'd0, cfg_ff.integral_limit};
         default:       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= GAIN_P_RST;
         cfg_ff.gain_i         <= GAIN_I_RST;
         cfg_ff.gain_d         <= GAIN_D_RST;
         cfg_ff.max_steer      <= MAX_STEER_RST;
         cfg_ff.integral_limit <= INT_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/lfps_mac.sv]
// ----------------------------------------------------------------------------
// lfps_mac: bit-serial multiply-accumulate
// Adds op_a times op_b to a preloaded accumulator, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module lfps_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lfps_pkg::WORD_W-1:0]   op_a,
   input  logic [lfps_pkg::MULB_W-1:0]   op_b,
   input  logic [lfps_pkg::WORD_W-1:0]   acc_init,
   output logic [lfps_pkg::WORD_W-1:0]   acc,
   output lfps_pkg::unit_sts_type        sts
);
   import lfps_pkg::*;

   logic              busy_ff, busy_in;
   logic [WORD_W-1:0] a_ff, a_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [MULB_W-1:0] b_ff, b_in;

   // load, then shift the multiplicand up and the multiplier down
   always_comb begin
      busy_in = busy_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = acc_init;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_in = acc_ff + a_ff;
            end
            a_in = a_ff << 1;
            b_in = b_ff >> 1;
         end
      end
   end

   assign acc      = acc_ff;
   assign sts.busy = busy_ff;
   assign sts.done = busy_ff && (b_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

endmodule

[hdl/lfps_div.sv]
// ----------------------------------------------------------------------------
// lfps_div: bit-serial restoring divider
// Produces a 16-bit quotient one bit a cycle, with a flag for larger quotients.
// ----------------------------------------------------------------------------
module lfps_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lfps_pkg::WORD_W-1:0]   dividend,
   input  logic [lfps_pkg::DIVS_W-1:0]   divisor,
   output logic [lfps_pkg::QUOT_W-1:0]   quot,
   output logic                          sat,
   output lfps_pkg::unit_sts_type        sts
);
   import lfps_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] dsh_ff, dsh_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic              sat_ff, sat_in;
   logic              ge;

   assign ge = (rem_ff >= dsh_ff);

   // one trial subtraction per cycle; the first step sets the overflow flag, not a quotient bit
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      sat_in  = sat_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUOT_W);
         rem_in  = dividend;
         dsh_in  = WORD_W'(divisor) << QUOT_W;
         q_in    = '0;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         if (cnt_ff == CNT_W'(QUOT_W)) begin
            sat_in = ge;
         end else begin
            q_in = {q_ff[QUOT_W-2:0], ge};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign quot     = q_ff;
   assign sat      = sat_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      sat_ff <= sat_in;
   end

endmodule

[hdl/line_follow_pid_steering.sv]
// ----------------------------------------------------------------------------
// line_follow_pid_steering: PID steering with anti-windup and speed scaling
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready   tdata: position, elapsed ms, base
//                                               speed; tuser: reset-state flag
//   rsp      out        rsp_tvalid/rsp_tready   tdata: steering, scaled speed
//   csr      in/out     APB, pready tied high   gains, max steer, integral limit
//
// One item at a time. A control transaction runs ten passes of a bit-serial
// multiply-accumulate unit (a load, a shift-and-add step per multiplier bit
// and a finish step), two passes of a bit-serial divider and one output
// step; pass lengths follow the bit lengths of the elapsed time, the gains
// and the speed scale. Synchronous reset clears the integral, the previous
// position and the registers to their defaults. The next transaction is taken
// while a result waits in the output register; a stalled result holds the
// sequencer only at its final step.
// ----------------------------------------------------------------------------
module line_follow_pid_steering (
   input  logic        clock,
   input  logic        reset,
   // tdata: line_offset [15:0], elapsed_ms [31:16], base_speed [47:32]
   input  logic [47:0] req_tdata,
   // tuser: op [0]
   input  logic        req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: steering [15:0], scaled_speed [31:16]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lfps_pkg::*;

   cfg_type           cfg;
   state_type         state_ff, state_in;
   logic              launched_ff, launched_in;
   logic [15:0]       e_ff, e_in;
   logic [15:0]       t_ff, t_in;
   logic [15:0]       b_ff, b_in;
   logic [INTG_W-1:0] integ_ff, integ_in;
   logic [15:0]       prev_ff, prev_in;
   logic [LIM_W-1:0]  lim_ff, lim_in;
   logic [WORD_W-1:0] hold_ff, hold_in;
   logic              neg_ff, neg_in;
   logic [15:0]       steer_ff, steer_in;
   logic [15:0]       rsp_steer_ff, rsp_steer_in;
   logic [15:0]       rsp_speed_ff, rsp_speed_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              mac_start;
   logic [WORD_W-1:0] mac_a;
   logic [MULB_W-1:0] mac_b;
   logic [WORD_W-1:0] mac_init;
   logic [WORD_W-1:0] mac_acc;
   unit_sts_type      mac_sts;
   logic              div_start;
   logic [WORD_W-1:0] div_n;
   logic [DIVS_W-1:0] div_d;
   logic [QUOT_W-1:0] div_quot;
   logic              div_sat;
   unit_sts_type      div_sts;

   logic              req_acc;
   logic              out_free;
   logic              b_neg;
   logic [14:0]       m;
   logic [15:0]       ae;
   logic [14:0]       ab;
   logic [18:0]       ten_m;
   logic [18:0]       seven_ae;
   logic [16:0]       three_m;
   logic signed [19:0] sc_raw;
   logic [18:0]       sc;
   logic [16:0]       de;
   logic signed [33:0] isum;
   logic signed [33:0] ilim;
   logic [15:0]       smag;

   lfps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lfps_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .start    (mac_start),
      .op_a     (mac_a),
      .op_b     (mac_b),
      .acc_init (mac_init),
      .acc      (mac_acc),
      .sts      (mac_sts)
   );

   lfps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .quot     (div_quot),
      .sat      (div_sat),
      .sts      (div_sts)
   );

   assign req_acc  = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // operand prep for speed scaling and the clamps
   assign b_neg    = b_ff[15];
   assign m        = (cfg.max_steer == '0) ? 15'd1 : cfg.max_steer;
   assign ae       = e_ff[15] ? (16'd0 - e_ff) : e_ff;
   assign ab       = !b_neg ? b_ff[14:0]
                   : ((b_ff == 16'h8000) ? 15'h7FFF : 15'((16'd0 - b_ff)));
   assign ten_m    = (19'(m) << 3) + (19'(m) << 1);
   assign seven_ae = (19'(ae) << 3) - 19'(ae);
   assign three_m  = (17'(m) << 1) + 17'(m);
   assign sc_raw   = signed'({1'b0, ten_m}) - signed'({1'b0, seven_ae});
   assign sc       = (sc_raw < signed'(20'(three_m))) ? 19'(three_m) : sc_raw[18:0];
   assign de       = {e_ff[15], e_ff} - {prev_ff[15], prev_ff};
   assign isum     = signed'(mac_acc[33:0]);
   assign ilim     = signed'({3'd0, lim_ff});
   assign smag     = (div_sat || (div_quot > {1'b0, m})) ? {1'b0, m} : div_quot;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_acc && (req_tuser == OP_STEP)) state_in = ST_LIM;
         ST_LIM:  if (mac_sts.done) state_in = ST_INT;
         ST_INT:  if (mac_sts.done) state_in = ST_PE;
         ST_PE:   if (mac_sts.done) state_in = ST_PK;
         ST_PK:   if (mac_sts.done) state_in = ST_IG;
         ST_IG:   if (mac_sts.done) state_in = ST_TM;
         ST_TM:   if (mac_sts.done) state_in = ST_DE;
         ST_DE:   if (mac_sts.done) state_in = ST_DM;
         ST_DM:   if (mac_sts.done) state_in = ST_DT;
         ST_DT:   if (mac_sts.done) state_in = ST_DV1;
         ST_DV1:  if (div_sts.done) state_in = ST_SP;
         ST_SP:   if (mac_sts.done) state_in = ST_DV2;
         ST_DV2:  if (div_sts.done) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign launched_in = (state_in == state_ff);

   // sequencer outputs: unit launches and operand selection
   always_comb begin
      req_tready = 1'b0;
      mac_start  = 1'b0;
      mac_a      = '0;
      mac_b      = '0;
      mac_init   = '0;
      div_start  = 1'b0;
      div_n      = hold_ff;
      div_d      = {1'b0, mac_acc[25:0], 8'd0};
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_LIM: begin
            mac_start = !launched_ff;
            mac_a     = WORD_W'(cfg.integral_limit);
            mac_b     = K_MILLI;
         end
         ST_INT: begin
            mac_start = !launched_ff;
            mac_a     = {{48{e_ff[15]}}, e_ff};
            mac_b     = MULB_W'(t_ff);
            mac_init  = {{32{integ_ff[INTG_W-1]}}, integ_ff};
         end
         ST_PE: begin
            mac_start = !launched_ff;
            mac_a     = {{48{e_ff[15]}}, e_ff};
            mac_b     = MULB_W'(cfg.gain_p);
         end
         ST_PK: begin
            mac_start = !launched_ff;
            mac_a     = mac_acc;
            mac_b     = K_MILLI;
         end
         ST_IG: begin
            mac_start = !launched_ff;
            mac_a     = {{32{integ_ff[INTG_W-1]}}, integ_ff};
            mac_b     = MULB_W'(cfg.gain_i);
            mac_init  = mac_acc;
         end
         ST_TM: begin
            mac_start = !launched_ff;
            mac_a     = mac_acc;
            mac_b     = MULB_W'(t_ff);
         end
         ST_DE: begin
            mac_start = !launched_ff;
            mac_a     = {{47{de[16]}}, de};
            mac_b     = MULB_W'(cfg.gain_d);
         end
         ST_DM: begin
            mac_start = !launched_ff;
            mac_a     = mac_acc;
            mac_b     = K_MICRO;
            mac_init  = hold_ff;
         end
         ST_DT: begin
            mac_start = !launched_ff;
            mac_a     = WORD_W'(t_ff);
            mac_b     = K_MILLI;
         end
         ST_DV1: begin
            div_start = !launched_ff;
         end
         ST_SP: begin
            mac_start = !launched_ff;
            mac_a     = WORD_W'(ab);
            mac_b     = MULB_W'(sc);
         end
         ST_DV2: begin
            div_start = !launched_ff;
            div_n     = mac_acc;
            div_d     = DIVS_W'(ten_m);
         end
         ST_OUT: ;
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      e_in         = e_ff;
      t_in         = t_ff;
      b_in         = b_ff;
      integ_in     = integ_ff;
      prev_in      = prev_ff;
      lim_in       = lim_ff;
      hold_in      = hold_ff;
      neg_in       = neg_ff;
      steer_in     = steer_ff;
      rsp_steer_in = rsp_steer_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               e_in = req_tdata[15:0];
               t_in = (req_tdata[31:16] == '0) ? 16'd1 : req_tdata[31:16];
               b_in = req_tdata[47:32];
               // reset-state transaction: clear the loop memory
               if (req_tuser == OP_RESET) begin
                  integ_in = '0;
                  prev_in  = '0;
               end
            end
         end
         ST_LIM: if (mac_sts.done) lim_in = mac_acc[LIM_W-1:0];
         ST_INT: begin
            // anti-windup clamp
            if (mac_sts.done) begin
               if (isum > ilim) begin
                  integ_in = INTG_W'(ilim);
               end else if (isum < -ilim) begin
                  integ_in = INTG_W'(-ilim);
               end else begin
                  integ_in = isum[INTG_W-1:0];
               end
            end
         end
         ST_TM: if (mac_sts.done) hold_in = mac_acc;
         ST_DM: begin
            // keep the numerator as sign and magnitude
            if (mac_sts.done) begin
               neg_in  = mac_acc[WORD_W-1];
               hold_in = mac_acc[WORD_W-1] ? (WORD_W'(0) - mac_acc) : mac_acc;
            end
         end
         ST_DV1: begin
            if (div_sts.done) begin
               steer_in = (neg_ff ^ b_neg) ? (16'd0 - smag) : smag;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_steer_in = steer_ff;
               rsp_speed_in = b_neg ? (16'd0 - div_quot) : div_quot;
               rsp_valid_in = 1'b1;
               prev_in      = e_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tdata  = {rsp_speed_ff, rsp_steer_ff};
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         integ_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      e_ff         <= e_in;
      t_ff         <= t_in;
      b_ff         <= b_in;
      lim_ff       <= lim_in;
      hold_ff      <= hold_in;
      neg_ff       <= neg_in;
      steer_ff     <= steer_in;
      rsp_steer_ff <= rsp_steer_in;
      rsp_speed_ff <= rsp_speed_in;
   end

endmodule

[verif/line_follow_pid_steering_tb.sv]
// ----------------------------------------------------------------------------
// line_follow_pid_steering_tb: self-checking bench for the PID steering block
// The bench sends step and reset-state transactions on the request stream and
// sets the gain, clamp and integral-bound registers over APB between phases,
// reading each one back. An internal steering predictor computes the expected
// steering and scaled speed for every accepted step. Each response is checked
// in order against those predictions. Both stream sides idle and stall at
// random.
// ----------------------------------------------------------------------------
module line_follow_pid_steering_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lfps_pkg::*;

   localparam int SETTLE_CYCLES = 300;    // longer than one control step
   localparam int STALL_LIMIT   = 2000;   // cycles without any transaction
   localparam int PHASE_ITEMS   = 150;

   typedef struct {
      bit                 op;
      logic signed [15:0] pos;
      logic [15:0]        ms;
      logic signed [15:0] base;
   } step_item_type;

   typedef struct {
      logic signed [15:0] steering;
      logic signed [15:0] speed;
   } steer_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic [47:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [4:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state and register copy
   cfg_type cfg_model = '{gain_p: GAIN_P_RST, gain_i: GAIN_I_RST, gain_d: GAIN_D_RST,
                          max_steer: MAX_STEER_RST, integral_limit: INT_LIMIT_RST};
   longint  integ_acc = 0;
   longint  last_pos  = 0;

   step_item_type    step_queue[$];
   steer_result_type steer_expect[$];
   step_item_type    req_cur;
   steer_result_type want;
   int               req_wait     = 0;
   int               rsp_wait     = 0;
   bit               req_idle_on  = 1'b0;
   bit               rsp_idle_on  = 1'b0;
   int               walk_pos     = 0;
   int               errors       = 0;
   int               stall_cycles = 0;

   line_follow_pid_steering u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Compute the steering result of one step, or clear state on a reset item.
   function automatic void steer_predict(input step_item_type it);
      longint           e, t, lim, num, steer, m, ae, ab, sc, spd;
      steer_result_type res;
      if (it.op == OP_RESET) begin
         integ_acc = 0;
         last_pos  = 0;
         return;
      end
      e = longint'(it.pos);
      t = (it.ms == 16'd0) ? 1 : longint'(it.ms);
      lim = longint'(cfg_model.integral_limit) * 1000;
      integ_acc = integ_acc + e * t;
      if (integ_acc > lim) integ_acc = lim;
      if (integ_acc < -lim) integ_acc = -lim;
      num = longint'(cfg_model.gain_p) * e * 1000 * t
          + longint'(cfg_model.gain_i) * integ_acc * t
          + longint'(cfg_model.gain_d) * (e - last_pos) * 1000000;
      steer = num / (256000 * t);
      // zero max_steer acts as one
      m = (cfg_model.max_steer == 15'd0) ? 1 : longint'(cfg_model.max_steer);
      if (steer > m) steer = m;
      if (steer < -m) steer = -m;
      ae = (e < 0) ? -e : e;
      ab = longint'(it.base);
      if (ab < 0) ab = -ab;
      if (ab > 32767) ab = 32767;
      sc = 10 * m - 7 * ae;
      if (sc < 3 * m) sc = 3 * m;
      spd = ab * sc / (10 * m);
      // reverse: flip both outputs
      if (it.base < 0) begin
         spd   = -spd;
         steer = -steer;
      end
      last_pos = e;
      res.steering = steer[15:0];
      res.speed    = spd[15:0];
      steer_expect.push_back(res);
   endfunction

   function automatic int draw_wait(input bit idle_on);
      if (!idle_on || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 15);
   endfunction

   function automatic void push_step(input bit op, input int pos, input int ms,
                                     input int base);
      step_item_type it;
      it.op   = op;
      it.pos  = 16'(pos);
      it.ms   = 16'(ms);
      it.base = 16'(base);
      step_queue.push_back(it);
   endfunction

   // Random step: full-range, drifting, small or corner positions.
   function automatic void push_random_step();
      int pos, ms, base;
      case ($urandom_range(0, 3))
         0: pos = int'($urandom_range(0, 65535)) - 32768;
         1: begin
            walk_pos = walk_pos + int'($urandom_range(0, 400)) - 200;
            if (walk_pos > 32767) walk_pos = 32767;
            if (walk_pos < -32768) walk_pos = -32768;
            pos = walk_pos;
         end
         2: pos = int'($urandom_range(0, 4000)) - 2000;
         default: begin
            case ($urandom_range(0, 4))
               0: pos = -32768;
               1: pos = 32767;
               2: pos = 0;
               3: pos = -1;
               default: pos = 1;
            endcase
         end
      endcase
      case ($urandom_range(0, 3))
         0: ms = 0;
         1: ms = $urandom_range(1, 40);
         2: ms = $urandom_range(0, 65535);
         default: ms = $urandom_range(1, 1000);
      endcase
      case ($urandom_range(0, 5))
         0: base = -32768;
         1: base = 32767;
         2: base = 0;
         default: base = int'($urandom_range(0, 65535)) - 32768;
      endcase
      push_step(($urandom_range(0, 19) == 0) ? OP_RESET : OP_STEP, pos, ms, base);
   endfunction

   // Write one register, update the predictor copy, then read it back.
   task automatic csr_write_check(input reg_idx_type idx, input logic [31:0] val);
      logic [31:0] want_rd;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_GAIN_P: begin
            cfg_model.gain_p = val[15:0];
            want_rd = {16'd0, val[15:0]};
         end
         REG_GAIN_I: begin
            cfg_model.gain_i = val[15:0];
            want_rd = {16'd0, val[15:0]};
         end
         REG_GAIN_D: begin
            cfg_model.gain_d = val[15:0];
            want_rd = {16'd0, val[15:0]};
         end
         REG_MAX_STEER: begin
            cfg_model.max_steer = val[14:0];
            want_rd = {17'd0, val[14:0]};
         end
         default: begin
            cfg_model.integral_limit = val[19:0];
            want_rd = {12'd0, val[19:0]};
         end
      endcase
      // read back: setup follows the write access directly
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== want_rd) begin
         $display("%0t: register %s readback: expected 0x%0h, actual 0x%0h",
                  $time, idx.name(), want_rd, csr_prdata);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic apply_config(input logic [15:0] kp, input logic [15:0] ki,
                               input logic [15:0] kd, input logic [14:0] mx,
                               input logic [19:0] lim);
      csr_write_check(REG_GAIN_P, {16'd0, kp});
      csr_write_check(REG_GAIN_I, {16'd0, ki});
      csr_write_check(REG_GAIN_D, {16'd0, kd});
      csr_write_check(REG_MAX_STEER, {17'd0, mx});
      csr_write_check(REG_INT_LIMIT, {12'd0, lim});
   endtask

   // Wait for all pending steps and results, then let the sequencer settle.
   task automatic drain();
      while (step_queue.size() != 0 || req_tvalid || steer_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase();
      req_idle_on = $urandom_range(0, 3) != 0;
      rsp_idle_on = $urandom_range(0, 3) != 0;
      repeat (PHASE_ITEMS) push_random_step();
      drain();
   endtask

   // Request driver: hold while stalled, predict on acceptance, then idle or load.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) begin
            steer_predict(req_cur);
            req_wait = draw_wait(req_idle_on);
         end
         if (req_wait > 0) begin
            req_wait--;
            req_tvalid <= 1'b0;
         end else if (step_queue.size() != 0) begin
            req_cur = step_queue.pop_front();
            req_tdata  <= {req_cur.base, req_cur.ms, req_cur.pos};
            req_tuser  <= req_cur.op;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response monitor: compare each transaction with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (steer_expect.size() == 0) begin
               $display("%0t: unexpected result: steering %0d, speed %0d", $time,
                        $signed(rsp_tdata[15:0]), $signed(rsp_tdata[31:16]));
               errors++;
            end else begin
               want = steer_expect.pop_front();
               if (rsp_tdata[15:0] !== want.steering) begin
                  $display("%0t: steering: expected %0d, actual %0d", $time,
                           want.steering, $signed(rsp_tdata[15:0]));
                  errors++;
               end
               if (rsp_tdata[31:16] !== want.speed) begin
                  $display("%0t: scaled_speed: expected %0d, actual %0d", $time,
                           want.speed, $signed(rsp_tdata[31:16]));
                  errors++;
               end
            end
            rsp_wait = draw_wait(rsp_idle_on);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed steps under reset defaults, no idling
      push_step(OP_RESET, 32767, 65535, -32768);  // reset item with junk fields
      push_step(OP_STEP, 0, 0, 0);                // zero elapsed time
      push_step(OP_STEP, 0, 100, 1000);
      push_step(OP_STEP, 32767, 65535, 32767);    // drive integral to upper bound
      push_step(OP_STEP, 32767, 65535, 32767);
      push_step(OP_STEP, -32768, 65535, -32768);  // most negative base speed
      push_step(OP_STEP, -32768, 1, -32767);
      push_step(OP_STEP, -32768, 0, 12345);
      push_step(OP_RESET, -5, 7, 9);              // clear integral and last position
      push_step(OP_STEP, 1750, 10, -20000);       // error at full scale: speed floor
      push_step(OP_STEP, -1, 1, 1);
      push_step(OP_STEP, 500, 20, -1);
      push_step(OP_STEP, -500, 20, 32767);
      push_step(OP_STEP, 0, 65535, -32768);
      push_step(OP_STEP, 1, 0, -32767);
      push_step(OP_STEP, 200, 5, 30000);          // mild error: no speed floor
      drain();

      // extremes of every register
      apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'd32767, 20'd1000000);
      random_phase();
      // all zero, including max_steer taken as one
      apply_config(16'd0, 16'd0, 16'd0, 15'd0, 20'd0);
      random_phase();
      apply_config(16'd256, 16'd4096, 16'd0, 15'd1, 20'd1);
      random_phase();
      repeat (6) begin
         apply_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)),
                      15'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 3000)
                                                      : $urandom_range(1, 32767)),
                      20'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 300)
                                                      : $urandom_range(0, 1000000)));
         random_phase();
      end

      if (steer_expect.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, steer_expect.size());
         errors++;
      end
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
